// File: sv/gnmu_pkg.sv
// ----------------------------------------------------------------------------
// gnmu_pkg
// Shared constants and types for the grid node momentum update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gnmu_pkg;

    // Fraction bits of the Q16.16 node quantities
    localparam int FRAC_BITS    = 16;
    // Fraction bits of the Q8.24 time step
    localparam int DT_FRAC_BITS = 24;
    // Configuration register width
    localparam int CFG_WIDTH    = 32;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TIME_STEP      = 1'b0,
        CFG_MASS_THRESHOLD = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_WIDTH-1:0] TIME_STEP_RESET      = 32'd16777;
    localparam logic [CFG_WIDTH-1:0] MASS_THRESHOLD_RESET = 32'd1;

endpackage

`default_nettype wire

// File: sv/gnmu_div_cell.sv
// ----------------------------------------------------------------------------
// gnmu_div_cell
// One restoring division step: develops one quotient bit and hands the
// partial remainder, the remaining dividend bits and the divisor onward.
// ----------------------------------------------------------------------------
`default_nettype none

module gnmu_div_cell #(
    parameter int W = 32,
    parameter int N = 48
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [N-1:0] i_num,
    input  wire logic [N-1:0] i_quo,
    input  wire logic [W-1:0] i_den,
    output logic      [W-1:0] o_rem,
    output logic      [N-1:0] o_num,
    output logic      [N-1:0] o_quo,
    output logic      [W-1:0] o_den
);

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rem;

    // Shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        trial = {i_rem, i_num[N-1]};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
        n_rem = ge ? diff[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        o_rem <= n_rem;
        o_num <= {i_num[N-2:0], 1'b0};
        o_quo <= {i_quo[N-2:0], ge};
        o_den <= i_den;
    end

endmodule

`default_nettype wire

// File: sv/gnmu_div_chain.sv
// ----------------------------------------------------------------------------
// gnmu_div_chain
// Signed Q16.16 divide of a magnitude by an unsigned mass: a row of
// division cells, one quotient bit each, with sign and saturation at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module gnmu_div_chain
    import gnmu_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_mag,
    input  wire logic         i_neg,
    input  wire logic [W-1:0] i_den,
    output logic      [W-1:0] o_quot
);

    localparam int N = W + FRAC_BITS;
    localparam logic [N-1:0] MAXP = {{(N-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [N-1:0] MINM = MAXP + N'(1);

    logic [W-1:0] rem [0:N];
    logic [N-1:0] num [0:N];
    logic [N-1:0] quo [0:N];
    logic [W-1:0] den [0:N];
    logic [N-1:0] r_neg;

    assign rem[0] = '0;
    assign num[0] = {i_mag, {FRAC_BITS{1'b0}}};
    assign quo[0] = '0;
    assign den[0] = i_den;

    // Row of division cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        gnmu_div_cell #(.W(W), .N(N)) u_cell (
            .i_clk (i_clk),
            .i_rem (rem[g]),
            .i_num (num[g]),
            .i_quo (quo[g]),
            .i_den (den[g]),
            .o_rem (rem[g+1]),
            .o_num (num[g+1]),
            .o_quo (quo[g+1]),
            .o_den (den[g+1])
        );
    end

    // Sign travels alongside the cells
    always_ff @(posedge i_clk) begin
        r_neg <= {r_neg[N-2:0], i_neg};
    end

    // Apply sign, clamp to signed range
    always_comb begin
        if (r_neg[N-1]) begin
            o_quot = (quo[N] > MINM) ? MINM[W-1:0] : (~quo[N][W-1:0] + W'(1));
        end else begin
            o_quot = (quo[N] > MAXP) ? MAXP[W-1:0] : quo[N][W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: sv/grid_node_momentum_update_unit.sv
// ----------------------------------------------------------------------------
// grid_node_momentum_update_unit
// Grid node update: acceleration = force / mass, momentum += dt * force,
// velocity = new momentum / mass, all saturated; nodes at or below the mass
// threshold pass momentum unchanged.
//
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               i_node_mass .. i_last_node
// result    out        o_result_valid (strobe)   o_accel_x .. o_end_of_sweep
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// One node is taken every cycle; busy stays low.
// The pipeline holds input, multiply and add stages, one division cell per
// quotient bit (DATA_WIDTH + 16 cells), and the output register.
// The result strobe is high for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the pipeline valid line and loads the
// register reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_node_momentum_update_unit
    import gnmu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_node_mass,
    input  wire logic [DATA_WIDTH-1:0] i_force_x,
    input  wire logic [DATA_WIDTH-1:0] i_force_y,
    input  wire logic [DATA_WIDTH-1:0] i_momentum_x,
    input  wire logic [DATA_WIDTH-1:0] i_momentum_y,
    input  wire logic                  i_last_node,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_WIDTH-1:0]  i_cfg_data,
    output logic                       o_result_valid,
    output logic      [DATA_WIDTH-1:0] o_accel_x,
    output logic      [DATA_WIDTH-1:0] o_accel_y,
    output logic      [DATA_WIDTH-1:0] o_vel_x,
    output logic      [DATA_WIDTH-1:0] o_vel_y,
    output logic      [DATA_WIDTH-1:0] o_new_momentum_x,
    output logic      [DATA_WIDTH-1:0] o_new_momentum_y,
    output logic                       o_node_active,
    output logic                       o_end_of_sweep
);

    localparam int W   = DATA_WIDTH;
    localparam int N   = W + FRAC_BITS;
    localparam int PW  = W + CFG_WIDTH;
    localparam int IW  = PW - DT_FRAC_BITS;
    localparam int SW  = IW + 1;
    localparam int LAT = N + 4;
    localparam logic [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [SW-1:0] SMIN = ~SMAX;

    // Configuration registers
    logic [CFG_WIDTH-1:0] r_dt;
    logic [CFG_WIDTH-1:0] r_thr;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= TIME_STEP_RESET;
            r_thr <= MASS_THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TIME_STEP:      r_dt  <= i_cfg_data;
                CFG_MASS_THRESHOLD: r_thr <= i_cfg_data;
                default:            r_dt  <= r_dt;
            endcase
        end
    end

    // Stage A: capture node, threshold compare
    logic         r_a_vld, r_a_act, r_a_last;
    logic [W-1:0] r_a_mass, r_a_fx, r_a_fy, r_a_mx, r_a_my;
    logic         n_a_act;

    assign n_a_act = ({{CFG_WIDTH{1'b0}}, i_node_mass} > {{W{1'b0}}, r_thr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_act  <= n_a_act;
        r_a_last <= i_last_node;
        r_a_mass <= i_node_mass;
        r_a_fx   <= i_force_x;
        r_a_fy   <= i_force_y;
        r_a_mx   <= i_momentum_x;
        r_a_my   <= i_momentum_y;
    end

    // Stage B: force magnitude times time step
    logic          r_b_vld, r_b_act, r_b_last, r_b_nfx, r_b_nfy;
    logic [W-1:0]  r_b_mass, r_b_mfx, r_b_mfy, r_b_mx, r_b_my;
    logic [PW-1:0] r_b_px, r_b_py;
    logic [W-1:0]  n_b_mfx, n_b_mfy;

    assign n_b_mfx = r_a_fx[W-1] ? (~r_a_fx + W'(1)) : r_a_fx;
    assign n_b_mfy = r_a_fy[W-1] ? (~r_a_fy + W'(1)) : r_a_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_act  <= r_a_act;
        r_b_last <= r_a_last;
        r_b_mass <= r_a_mass;
        r_b_nfx  <= r_a_fx[W-1];
        r_b_nfy  <= r_a_fy[W-1];
        r_b_mfx  <= n_b_mfx;
        r_b_mfy  <= n_b_mfy;
        r_b_mx   <= r_a_mx;
        r_b_my   <= r_a_my;
        r_b_px   <= PW'(n_b_mfx) * PW'(r_dt);
        r_b_py   <= PW'(n_b_mfy) * PW'(r_dt);
    end

    // Stage C: truncated increment added to momentum, saturated; inactive nodes keep momentum
    logic          r_c_vld, r_c_act, r_c_last, r_c_nfx, r_c_nfy;
    logic [W-1:0]  r_c_mass, r_c_mfx, r_c_mfy, r_c_mx, r_c_my;
    logic [SW-1:0] sum_x, sum_y;
    logic [W-1:0]  n_c_mx, n_c_my;

    always_comb begin
        sum_x = {{(SW-W){r_b_mx[W-1]}}, r_b_mx}
              + (r_b_nfx ? -{1'b0, r_b_px[PW-1:DT_FRAC_BITS]}
                         :  {1'b0, r_b_px[PW-1:DT_FRAC_BITS]});
        sum_y = {{(SW-W){r_b_my[W-1]}}, r_b_my}
              + (r_b_nfy ? -{1'b0, r_b_py[PW-1:DT_FRAC_BITS]}
                         :  {1'b0, r_b_py[PW-1:DT_FRAC_BITS]});
        if (!r_b_act) begin
            n_c_mx = r_b_mx;
        end else if ($signed(sum_x) > $signed(SMAX)) begin
            n_c_mx = SMAX[W-1:0];
        end else if ($signed(sum_x) < $signed(SMIN)) begin
            n_c_mx = SMIN[W-1:0];
        end else begin
            n_c_mx = sum_x[W-1:0];
        end
        if (!r_b_act) begin
            n_c_my = r_b_my;
        end else if ($signed(sum_y) > $signed(SMAX)) begin
            n_c_my = SMAX[W-1:0];
        end else if ($signed(sum_y) < $signed(SMIN)) begin
            n_c_my = SMIN[W-1:0];
        end else begin
            n_c_my = sum_y[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_act  <= r_b_act;
        r_c_last <= r_b_last;
        r_c_mass <= r_b_mass;
        r_c_nfx  <= r_b_nfx;
        r_c_nfy  <= r_b_nfy;
        r_c_mfx  <= r_b_mfx;
        r_c_mfy  <= r_b_mfy;
        r_c_mx   <= n_c_mx;
        r_c_my   <= n_c_my;
    end

    // Four division chains
    logic [W-1:0] mag_mx, mag_my;
    logic [W-1:0] q_ax, q_ay, q_vx, q_vy;

    assign mag_mx = r_c_mx[W-1] ? (~r_c_mx + W'(1)) : r_c_mx;
    assign mag_my = r_c_my[W-1] ? (~r_c_my + W'(1)) : r_c_my;

    gnmu_div_chain #(.W(W)) u_div_ax (
        .i_clk(i_clk), .i_mag(r_c_mfx), .i_neg(r_c_nfx), .i_den(r_c_mass), .o_quot(q_ax)
    );
    gnmu_div_chain #(.W(W)) u_div_ay (
        .i_clk(i_clk), .i_mag(r_c_mfy), .i_neg(r_c_nfy), .i_den(r_c_mass), .o_quot(q_ay)
    );
    gnmu_div_chain #(.W(W)) u_div_vx (
        .i_clk(i_clk), .i_mag(mag_mx), .i_neg(r_c_mx[W-1]), .i_den(r_c_mass), .o_quot(q_vx)
    );
    gnmu_div_chain #(.W(W)) u_div_vy (
        .i_clk(i_clk), .i_mag(mag_my), .i_neg(r_c_my[W-1]), .i_den(r_c_mass), .o_quot(q_vy)
    );

    // Sideband line matching the division latency
    logic [N-1:0] r_d_vld, r_d_act, r_d_last;
    logic [W-1:0] r_d_mx [0:N-1];
    logic [W-1:0] r_d_my [0:N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= '0;
        end else begin
            r_d_vld <= {r_d_vld[N-2:0], r_c_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_act  <= {r_d_act[N-2:0], r_c_act};
        r_d_last <= {r_d_last[N-2:0], r_c_last};
        r_d_mx[0] <= r_c_mx;
        r_d_my[0] <= r_c_my;
        for (int k = 1; k < N; k++) begin
            r_d_mx[k] <= r_d_mx[k-1];
            r_d_my[k] <= r_d_my[k-1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_d_vld[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_accel_x        <= r_d_act[N-1] ? q_ax : '0;
        o_accel_y        <= r_d_act[N-1] ? q_ay : '0;
        o_vel_x          <= r_d_act[N-1] ? q_vx : '0;
        o_vel_y          <= r_d_act[N-1] ? q_vy : '0;
        o_new_momentum_x <= r_d_mx[N-1];
        o_new_momentum_y <= r_d_my[N-1];
        o_node_active    <= r_d_act[N-1];
        o_end_of_sweep   <= r_d_last[N-1];
    end

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("result strobe missing after accepted node");

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_node_active) |->
            (o_accel_x == '0 && o_accel_y == '0 && o_vel_x == '0 && o_vel_y == '0))
        else $error("inactive node with nonzero acceleration or velocity");

    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_node) |-> ##LAT o_end_of_sweep)
        else $error("sweep end marker lost");

endmodule

`default_nettype wire
